// File: src/rpi_pkg.sv
// Shared constants, types and helpers for the ray/plane intersection block.
// No dependencies; every other file imports this package.
package rpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int DIVW      = W + FRAC_BITS + 1;   // dividend magnitude bits
    localparam int QW        = DIVW;                // quotient bits

    localparam logic [2:0] REG_PLANE_X  = 3'd0;
    localparam logic [2:0] REG_PLANE_Y  = 3'd1;
    localparam logic [2:0] REG_PLANE_Z  = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;
    localparam logic [2:0] REG_MIN_PROD = 3'd6;

    // Ray word carried down the pipeline.
    typedef struct packed {
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        logic signed [W-1:0] oz;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] dz;
        logic                from_in;
    } ray_t;

    // Status from the dot product stage into the divider.
    typedef struct packed {
        logic valid;
        logic reject;
    } ctl_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+47:0] x);
        logic signed [W+47:0] mx;
        logic signed [W+47:0] mn;
        mx = (W+48)'(signed'({1'b0, {(W-1){1'b1}}}));
        mn = -mx - 1;
        if (x > mx)
            return {1'b0, {(W-1){1'b1}}};
        else if (x < mn)
            return {1'b1, {(W-1){1'b0}}};
        else
            return x[W-1:0];
    endfunction

endpackage

// File: src/rpi_dot.sv
// Dot product stages: forms a = n.d and b = n.(p0-o) with rounding and saturation.
// Depends on rpi_pkg. Three register stages: products, sums, round/saturate.
module rpi_dot
    import rpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ray_t                in_ray,
    input  logic signed [W-1:0] plane_x,
    input  logic signed [W-1:0] plane_y,
    input  logic signed [W-1:0] plane_z,
    input  logic signed [W-1:0] normal_x,
    input  logic signed [W-1:0] normal_y,
    input  logic signed [W-1:0] normal_z,
    output logic                out_valid,
    output ray_t                out_ray,
    output logic signed [W-1:0] out_a,
    output logic signed [W-1:0] out_b
);

    localparam int PW = 2*W + 1;   // product with a 33-bit difference
    localparam int SW = PW + 2;

    logic               v1_reg, v2_reg, v3_reg;
    ray_t               r1_reg, r2_reg, r3_reg;
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic signed [SW-1:0] sa_reg, sb_reg;
    logic signed [W-1:0]  a_reg, b_reg;
    logic signed [SW-1:0] ra_next, rb_next;

    logic signed [W:0] diff_x, diff_y, diff_z;

    assign diff_x = (W+1)'(plane_x) - (W+1)'(in_ray.ox);
    assign diff_y = (W+1)'(plane_y) - (W+1)'(in_ray.oy);
    assign diff_z = (W+1)'(plane_z) - (W+1)'(in_ray.oz);

    // Round half up then floor shift; the sum is exact, so it is rounded only once.
    assign ra_next = (sa_reg + SW'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    assign rb_next = (sb_reg + SW'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg    <= in_ray;
        pa_reg[0] <= PW'(normal_x * in_ray.dx);
        pa_reg[1] <= PW'(normal_y * in_ray.dy);
        pa_reg[2] <= PW'(normal_z * in_ray.dz);
        pb_reg[0] <= PW'(normal_x * diff_x);
        pb_reg[1] <= PW'(normal_y * diff_y);
        pb_reg[2] <= PW'(normal_z * diff_z);
        r2_reg    <= r1_reg;
        sa_reg    <= SW'(pa_reg[0]) + SW'(pa_reg[1]) + SW'(pa_reg[2]);
        sb_reg    <= SW'(pb_reg[0]) + SW'(pb_reg[1]) + SW'(pb_reg[2]);
        r3_reg    <= r2_reg;
        a_reg     <= sat_w((W+48)'(ra_next));
        b_reg     <= sat_w((W+48)'(rb_next));
    end

    assign out_valid = v3_reg;
    assign out_ray   = r3_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;

endmodule

// File: src/rpi_div.sv
// Pipelined restoring divider: t = sat((b << FRAC_BITS) / a), truncated toward zero.
// Depends on rpi_pkg. One quotient bit per stage: input register, QW stages, then sign/saturate stage.
module rpi_div
    import rpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                in_ctl,
    input  ray_t                in_ray,
    input  logic signed [W-1:0] in_a,
    input  logic signed [W-1:0] in_b,
    output ctl_t                out_ctl,
    output ray_t                out_ray,
    output logic signed [W-1:0] out_t
);

    localparam int NS = QW;

    ctl_t             ctl_reg  [NS+1];
    ray_t             ray_reg  [NS+1];
    logic             neg_reg  [NS+1];
    logic [W-1:0]     den_reg  [NS+1];
    logic [DIVW-1:0]  num_reg  [NS+1];
    logic [W:0]       rem_reg  [NS+1];
    logic signed [W-1:0] t_reg;
    ctl_t             ctl_o_reg;
    ray_t             ray_o_reg;

    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;
    logic signed [QW:0] sq;

    assign mag_a = in_a[W-1] ? W'(-in_a) : W'(in_a);
    assign mag_b = in_b[W-1] ? W'(-in_b) : W'(in_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
                ctl_reg[i] <= '0;
            ctl_o_reg <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
            for (int i = 1; i <= NS; i++)
                ctl_reg[i] <= ctl_reg[i-1];
            ctl_o_reg <= ctl_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        ray_reg[0] <= in_ray;
        neg_reg[0] <= in_a[W-1] ^ in_b[W-1];
        den_reg[0] <= mag_a;
        num_reg[0] <= {1'b0, mag_b, {FRAC_BITS{1'b0}}};
        rem_reg[0] <= '0;
        for (int i = 1; i <= NS; i++)
        begin
            logic [W+1:0] trial;
            logic [W+1:0] shifted;
            shifted = {rem_reg[i-1], num_reg[i-1][DIVW-1]};
            trial   = shifted - {2'b00, den_reg[i-1]};
            ray_reg[i] <= ray_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
            den_reg[i] <= den_reg[i-1];
            if (!trial[W+1])
            begin
                rem_reg[i] <= trial[W:0];
                num_reg[i] <= {num_reg[i-1][DIVW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= shifted[W:0];
                num_reg[i] <= {num_reg[i-1][DIVW-2:0], 1'b0};
            end
        end
        ray_o_reg <= ray_reg[NS];
        t_reg     <= sat_w((W+48)'(sq));
    end

    // After QW shifts the dividend register holds the quotient magnitude.
    assign sq = neg_reg[NS] ? -$signed({1'b0, num_reg[NS]}) : $signed({1'b0, num_reg[NS]});

    assign out_ctl = ctl_o_reg;
    assign out_ray = ray_o_reg;
    assign out_t   = t_reg;

endmodule

// File: src/rpi_coord.sv
// Coordinate stages: o + round(d*t) per axis, saturated, masked when no hit.
// Depends on rpi_pkg. Two register stages: product, then round/add/saturate.
module rpi_coord
    import rpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                in_ctl,
    input  ray_t                in_ray,
    input  logic signed [W-1:0] in_t,
    output logic                out_valid,
    output logic                out_hit,
    output logic signed [W-1:0] out_x,
    output logic signed [W-1:0] out_y,
    output logic signed [W-1:0] out_z
);

    localparam int PW = 2*W;

    ctl_t               c1_reg;
    logic               v2_reg, h2_reg;
    logic signed [W-1:0]  o_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [W-1:0]  q_reg [3];
    logic signed [W-1:0]  q_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [PW:0] r;
            r = ((PW+1)'(p_reg[i]) + (PW+1)'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
            q_next[i] = c1_reg.reject ? '0 : sat_w((W+48)'(r) + (W+48)'(o_reg[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            v2_reg <= 1'b0;
        end
        else
        begin
            c1_reg <= in_ctl;
            v2_reg <= c1_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg[0] <= in_ray.ox;
        o_reg[1] <= in_ray.oy;
        o_reg[2] <= in_ray.oz;
        p_reg[0] <= in_ray.dx * in_t;
        p_reg[1] <= in_ray.dy * in_t;
        p_reg[2] <= in_ray.dz * in_t;
        h2_reg   <= !c1_reg.reject;
        for (int i = 0; i < 3; i++)
            q_reg[i] <= q_next[i];
    end

    assign out_valid = v2_reg;
    assign out_hit   = h2_reg;
    assign out_x     = q_reg[0];
    assign out_y     = q_reg[1];
    assign out_z     = q_reg[2];

endmodule

// File: src/ray_plane_intersect_top.sv
// Top level of the ray/plane intersection pipeline with its configuration registers.
// Depends on rpi_pkg, rpi_dot, rpi_div and rpi_coord.

// One ray is taken in every cycle (busy stays low) and its result word appears
// on the result ports with done high once it has passed the dot product, divider
// and coordinate stages; the divider resolves one quotient bit per stage.
// The receiver cannot stall, so results must be taken when done is high.
// Configuration writes are always ready and take effect at once; write only
// while no ray is in flight.
module ray_plane_intersect_top
    import rpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [W-1:0] origin_x,
    input  logic signed [W-1:0] origin_y,
    input  logic signed [W-1:0] origin_z,
    input  logic signed [W-1:0] dir_x,
    input  logic signed [W-1:0] dir_y,
    input  logic signed [W-1:0] dir_z,
    input  logic                from_inside,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [W-1:0]        cfg_data,
    output logic                done,
    output logic                hit,
    output logic signed [W-1:0] hit_x,
    output logic signed [W-1:0] hit_y,
    output logic signed [W-1:0] hit_z
);

    logic signed [W-1:0] plane_x_reg, plane_y_reg, plane_z_reg;
    logic signed [W-1:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic [W-2:0]        min_prod_reg;

    ray_t                in_ray;
    logic                d_valid;
    ray_t                d_ray;
    logic signed [W-1:0] d_a, d_b;
    logic signed [2*W-1:0] ab_prod;
    logic signed [2*W-1:0] thresh;
    ctl_t                d_ctl;
    ctl_t                q_ctl;
    ray_t                q_ray;
    logic signed [W-1:0] q_t;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_x_reg  <= '0;
            plane_y_reg  <= '0;
            plane_z_reg  <= '0;
            normal_x_reg <= '0;
            normal_y_reg <= W'(1 <<< FRAC_BITS);
            normal_z_reg <= '0;
            min_prod_reg <= (W-1)'(7);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PLANE_X:  plane_x_reg  <= cfg_data;
                REG_PLANE_Y:  plane_y_reg  <= cfg_data;
                REG_PLANE_Z:  plane_z_reg  <= cfg_data;
                REG_NORMAL_X: normal_x_reg <= cfg_data;
                REG_NORMAL_Y: normal_y_reg <= cfg_data;
                REG_NORMAL_Z: normal_z_reg <= cfg_data;
                REG_MIN_PROD: min_prod_reg <= cfg_data[W-2:0];
                default:      ;
            endcase
        end
    end

    assign in_ray = '{ox: origin_x, oy: origin_y, oz: origin_z,
                      dx: dir_x, dy: dir_y, dz: dir_z, from_in: from_inside};

    rpi_dot u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_ray   (in_ray),
        .plane_x  (plane_x_reg),
        .plane_y  (plane_y_reg),
        .plane_z  (plane_z_reg),
        .normal_x (normal_x_reg),
        .normal_y (normal_y_reg),
        .normal_z (normal_z_reg),
        .out_valid(d_valid),
        .out_ray  (d_ray),
        .out_a    (d_a),
        .out_b    (d_b)
    );

    // Rejection: flag, parallel ray, or a*b under the threshold.
    assign ab_prod = d_a * d_b;
    assign thresh  = (2*W)'({1'b0, min_prod_reg}) <<< FRAC_BITS;
    assign d_ctl.valid  = d_valid;
    assign d_ctl.reject = d_ray.from_in || (d_a == '0) || (ab_prod < thresh);

    rpi_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ctl (d_ctl),
        .in_ray (d_ray),
        .in_a   (d_a),
        .in_b   (d_b),
        .out_ctl(q_ctl),
        .out_ray(q_ray),
        .out_t  (q_t)
    );

    rpi_coord u_coord (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (q_ctl),
        .in_ray   (q_ray),
        .in_t     (q_t),
        .out_valid(done),
        .out_hit  (hit),
        .out_x    (hit_x),
        .out_y    (hit_y),
        .out_z    (hit_z)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> (hit_x == '0 && hit_y == '0 && hit_z == '0))
        else $error("miss result carries nonzero coordinates");

    a_inside_miss: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid && d_ray.from_in |-> d_ctl.reject)
        else $error("inside ray not rejected");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline reported busy");

endmodule
